// ===== rtl/slp_pkg.sv =====
// Shared types and constants for the serial flash page loader.
// No dependencies; slp_front, slp_fifo, slp_back and the core refer to this package by scoped names.
package slp_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CMD_HOST     = 2'd0,
    CMD_WINDOW   = 2'd1,
    CMD_READBACK = 2'd2,
    CMD_DONE     = 2'd3
  } cmd_e;

  // Result actions
  typedef enum logic [2:0] {
    ACT_SEND  = 3'd0,
    ACT_ERASE = 3'd1,
    ACT_FILL  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4,
    ACT_START = 3'd5
  } action_e;

  // Protocol phases
  typedef enum logic [3:0] {
    PH_HANDSHAKE = 4'd0,
    PH_ADDR      = 4'd1,
    PH_DATA      = 4'd2,
    PH_CHECK     = 4'd3,
    PH_ERASE     = 4'd4,
    PH_FILL      = 4'd5,
    PH_WRITE     = 4'd6,
    PH_VERIFY    = 4'd7,
    PH_STARTED   = 4'd8
  } phase_e;

  localparam logic [7:0] CH_PROMPT   = 8'h3E; // '>'
  localparam logic [7:0] CH_HELLO    = 8'h3C; // '<'
  localparam logic [7:0] CH_BAD_SUM  = 8'h40; // '@'
  localparam logic [7:0] CH_BAD_VFY  = 8'h24; // '$'
  localparam logic [7:0] CH_OK       = 8'h21; // '!'
  localparam logic [7:0] CH_ZERO     = 8'h30; // '0'
  localparam logic [31:0] ADDR_START = 32'hFFFF_FFFF;

  localparam int unsigned REPLY_LEN = 5;

  // One queued job: either a single result or the page-size reply sequence
  typedef struct packed {
    logic          size_reply;
    action_e       action;
    logic [7:0]    tx_byte;
    logic [31:0]   flash_address;
    logic [15:0]   fill_word;
  } job_t;

endpackage

// ===== rtl/slp_in_if.sv =====
// Input channel of the page loader: valid/ready handshake with the command payload.
// Depends on nothing.
interface slp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic [7:0] flash_byte;

  modport source(output valid, output command, output rx_byte, output flash_byte,
                 input ready);
  modport sink(input valid, input command, input rx_byte, input flash_byte,
               output ready);
endinterface

// ===== rtl/slp_out_if.sv =====
// Result channel of the page loader: valid/ready handshake with the action payload.
// Depends on nothing.
interface slp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  tx_byte;
  logic [31:0] flash_address;
  logic [15:0] fill_word;
  logic        last;

  modport source(output valid, output action, output tx_byte, output flash_address,
                 output fill_word, output last, input ready);
  modport sink(input valid, input action, input tx_byte, input flash_address,
               input fill_word, input last, output ready);
endinterface

// ===== rtl/slp_front.sv =====
// Front end: accepts input transfers, runs the protocol phases, owns the page buffer
// and pushes one job per result-producing input. Depends on slp_pkg and slp_in_if.
module slp_front #(
  parameter int PAGE     = 128,
  parameter int ATTEMPTS = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  slp_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output slp_pkg::job_t  job_o
);

  localparam int CW = (PAGE > 4) ? $clog2(PAGE) : 2;
  localparam int IW = $clog2(PAGE);
  localparam logic [CW:0] PAGE_W = (CW + 1)'(PAGE);

  slp_pkg::phase_e phase_q, phase_d;
  logic [2:0]      win_q, win_d;
  logic [31:0]     addr_q, addr_d;
  logic [CW-1:0]   bc_q, bc_d;
  logic [7:0]      sum_q, sum_d;

  logic [7:0]      mem [PAGE];
  logic [7:0]      rd_a_q, rd_b_q;
  logic            ok_a_q, ok_b_q;
  logic [CW:0]     base_a, base_b;
  logic            wr_en;

  logic            acc, is_host, is_win, is_rb, is_done;
  logic [CW:0]     bc_inc, bc_nx2;
  logic [31:0]     addr_shift;
  logic [15:0]     fill_val;

  assign in_i.ready = !full_i;
  assign acc     = in_i.valid && in_i.ready;
  assign is_host = acc && (in_i.command == slp_pkg::CMD_HOST);
  assign is_win  = acc && (in_i.command == slp_pkg::CMD_WINDOW);
  assign is_rb   = acc && (in_i.command == slp_pkg::CMD_READBACK);
  assign is_done = acc && (in_i.command == slp_pkg::CMD_DONE);

  assign bc_inc     = {1'b0, bc_q} + (CW + 1)'(1);
  assign bc_nx2     = {1'b0, bc_q} + (CW + 1)'(2);
  assign addr_shift = {addr_q[23:0], in_i.rx_byte};
  assign fill_val   = {ok_b_q ? rd_b_q : 8'h00, ok_a_q ? rd_a_q : 8'h00};

  // Next state
  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    addr_d  = addr_q;
    bc_d    = bc_q;
    sum_d   = sum_q;
    wr_en   = 1'b0;
    case (phase_q)
      slp_pkg::PH_HANDSHAKE: begin
        if (is_win) begin
          if (win_q < 3'(ATTEMPTS)) begin
            win_d = win_q + 3'd1;
          end else begin
            phase_d = slp_pkg::PH_STARTED;
          end
        end else if (is_host && win_q != 3'd0 && in_i.rx_byte == slp_pkg::CH_HELLO) begin
          phase_d = slp_pkg::PH_ADDR;
          bc_d    = '0;
        end
      end
      slp_pkg::PH_ADDR: begin
        if (is_host) begin
          addr_d = addr_shift;
          if (bc_q >= CW'(3)) begin
            bc_d    = '0;
            sum_d   = 8'h00;
            phase_d = (addr_shift == slp_pkg::ADDR_START) ? slp_pkg::PH_STARTED
                                                          : slp_pkg::PH_DATA;
          end else begin
            bc_d = bc_inc[CW-1:0];
          end
        end
      end
      slp_pkg::PH_DATA: begin
        if (is_host) begin
          wr_en = 1'b1;
          sum_d = sum_q + in_i.rx_byte;
          if (bc_inc >= PAGE_W) begin
            phase_d = slp_pkg::PH_CHECK;
            bc_d    = '0;
          end else begin
            bc_d = bc_inc[CW-1:0];
          end
        end
      end
      slp_pkg::PH_CHECK: begin
        if (is_host) begin
          phase_d = (in_i.rx_byte != sum_q) ? slp_pkg::PH_ADDR : slp_pkg::PH_ERASE;
          bc_d    = '0;
        end
      end
      slp_pkg::PH_ERASE: begin
        if (is_done) begin
          phase_d = slp_pkg::PH_FILL;
          bc_d    = '0;
        end
      end
      slp_pkg::PH_FILL: begin
        if (is_done) begin
          if (bc_nx2 >= PAGE_W) begin
            phase_d = slp_pkg::PH_WRITE;
            bc_d    = '0;
          end else begin
            bc_d = bc_nx2[CW-1:0];
          end
        end
      end
      slp_pkg::PH_WRITE: begin
        if (is_done) begin
          phase_d = slp_pkg::PH_VERIFY;
          bc_d    = '0;
        end
      end
      slp_pkg::PH_VERIFY: begin
        if (is_rb) begin
          if (rd_a_q != in_i.flash_byte || bc_inc >= PAGE_W) begin
            phase_d = slp_pkg::PH_ADDR;
            bc_d    = '0;
          end else begin
            bc_d = bc_inc[CW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Job output
  always_comb begin
    push_o              = 1'b0;
    job_o.size_reply    = 1'b0;
    job_o.action        = slp_pkg::ACT_SEND;
    job_o.tx_byte       = 8'h00;
    job_o.flash_address = 32'h0;
    job_o.fill_word     = 16'h0;
    case (phase_q)
      slp_pkg::PH_HANDSHAKE: begin
        if (is_win) begin
          push_o = 1'b1;
          if (win_q < 3'(ATTEMPTS)) begin
            job_o.tx_byte = slp_pkg::CH_PROMPT;
          end else begin
            job_o.action = slp_pkg::ACT_START;
          end
        end else if (is_host && win_q != 3'd0 && in_i.rx_byte == slp_pkg::CH_HELLO) begin
          push_o           = 1'b1;
          job_o.size_reply = 1'b1;
        end
      end
      slp_pkg::PH_ADDR: begin
        if (is_host && bc_q >= CW'(3) && addr_shift == slp_pkg::ADDR_START) begin
          push_o       = 1'b1;
          job_o.action = slp_pkg::ACT_START;
        end
      end
      slp_pkg::PH_CHECK: begin
        if (is_host) begin
          push_o = 1'b1;
          if (in_i.rx_byte != sum_q) begin
            job_o.tx_byte = slp_pkg::CH_BAD_SUM;
          end else begin
            job_o.action        = slp_pkg::ACT_ERASE;
            job_o.flash_address = addr_q;
          end
        end
      end
      slp_pkg::PH_ERASE: begin
        if (is_done) begin
          push_o              = 1'b1;
          job_o.action        = slp_pkg::ACT_FILL;
          job_o.flash_address = addr_q;
          job_o.fill_word     = fill_val;
        end
      end
      slp_pkg::PH_FILL: begin
        if (is_done) begin
          push_o              = 1'b1;
          job_o.flash_address = addr_q;
          if (bc_nx2 >= PAGE_W) begin
            job_o.action = slp_pkg::ACT_WRITE;
          end else begin
            job_o.action        = slp_pkg::ACT_FILL;
            job_o.flash_address = addr_q + 32'(bc_nx2);
            job_o.fill_word     = fill_val;
          end
        end
      end
      slp_pkg::PH_WRITE: begin
        if (is_done) begin
          push_o              = 1'b1;
          job_o.action        = slp_pkg::ACT_READ;
          job_o.flash_address = addr_q;
        end
      end
      slp_pkg::PH_VERIFY: begin
        if (is_rb) begin
          push_o = 1'b1;
          if (rd_a_q != in_i.flash_byte) begin
            job_o.tx_byte = slp_pkg::CH_BAD_VFY;
          end else if (bc_inc >= PAGE_W) begin
            job_o.tx_byte = slp_pkg::CH_OK;
          end else begin
            job_o.action        = slp_pkg::ACT_READ;
            job_o.flash_address = addr_q + 32'(bc_inc);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slp_pkg::PH_HANDSHAKE;
      win_q   <= 3'd0;
      addr_q  <= 32'h0;
      bc_q    <= '0;
      sum_q   <= 8'h00;
    end else begin
      phase_q <= phase_d;
      win_q   <= win_d;
      addr_q  <= addr_d;
      bc_q    <= bc_d;
      sum_q   <= sum_d;
    end
  end

  // Prefetch the bytes the next fill or verify step will need
  assign base_a = (phase_d == slp_pkg::PH_FILL) ? ({1'b0, bc_d} + (CW + 1)'(2))
                                                : {1'b0, bc_d};
  assign base_b = base_a + (CW + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[bc_q[IW-1:0]] <= in_i.rx_byte;
    end
    rd_a_q <= mem[base_a[IW-1:0]];
    rd_b_q <= mem[base_b[IW-1:0]];
    ok_a_q <= (base_a < PAGE_W);
    ok_b_q <= (base_b < PAGE_W);
  end

  a_started_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == slp_pkg::PH_STARTED |=> phase_q == slp_pkg::PH_STARTED)
    else $error("left the started phase");

  a_counter_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == slp_pkg::PH_DATA || phase_q == slp_pkg::PH_VERIFY ||
     phase_q == slp_pkg::PH_FILL) |-> ({1'b0, bc_q} < PAGE_W))
    else $error("byte counter beyond page");

endmodule

// ===== rtl/slp_fifo.sv =====
// Short job queue between front and back ends.
// Depends on slp_pkg for the job type.
module slp_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  slp_pkg::job_t data_i,
  input  logic          pop_i,
  output slp_pkg::job_t data_o,
  output logic          valid_o,
  output logic          full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  slp_pkg::job_t entry_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == NW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + NW'(1);
      2'b01:   cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(DEPTH))
    else $error("queue count overflow");

  a_push_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

endmodule

// ===== rtl/slp_back.sv =====
// Back end: pops jobs and presents them as result transfers from an output register,
// expanding the page-size reply into five bytes. Depends on slp_pkg and slp_out_if.
module slp_back #(
  parameter int PAGE = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  slp_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          pop_o,
  slp_out_if.source     out_o
);

  localparam logic [7:0] DIG3 = 8'(32'(slp_pkg::CH_ZERO) + (PAGE / 1000) % 10);
  localparam logic [7:0] DIG2 = 8'(32'(slp_pkg::CH_ZERO) + (PAGE / 100) % 10);
  localparam logic [7:0] DIG1 = 8'(32'(slp_pkg::CH_ZERO) + (PAGE / 10) % 10);
  localparam logic [7:0] DIG0 = 8'(32'(slp_pkg::CH_ZERO) + PAGE % 10);
  localparam int SW = $clog2(slp_pkg::REPLY_LEN);

  slp_pkg::job_t cur_q, cur_d;
  logic [SW-1:0] step_q, step_d;
  logic          vld_q, vld_d;
  logic          out_acc, final_res;
  logic [7:0]    reply_byte;

  assign out_acc   = out_o.valid && out_o.ready;
  assign final_res = !cur_q.size_reply || step_q == SW'(slp_pkg::REPLY_LEN - 1);
  assign pop_o     = job_valid_i && (!vld_q || (out_acc && final_res));

  always_comb begin
    case (step_q)
      SW'(0):  reply_byte = DIG3;
      SW'(1):  reply_byte = DIG2;
      SW'(2):  reply_byte = DIG1;
      SW'(3):  reply_byte = DIG0;
      default: reply_byte = slp_pkg::CH_OK;
    endcase
  end

  always_comb begin
    cur_d  = cur_q;
    step_d = step_q;
    vld_d  = vld_q;
    if (pop_o) begin
      cur_d  = job_i;
      step_d = '0;
      vld_d  = 1'b1;
    end else if (out_acc && final_res) begin
      vld_d = 1'b0;
    end else if (out_acc) begin
      step_d = step_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      step_q <= '0;
    end else begin
      vld_q  <= vld_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign out_o.valid         = vld_q;
  assign out_o.action        = cur_q.action;
  assign out_o.tx_byte       = cur_q.size_reply ? reply_byte : cur_q.tx_byte;
  assign out_o.flash_address = cur_q.flash_address;
  assign out_o.fill_word     = cur_q.fill_word;
  assign out_o.last          = final_res;

  a_step_only_in_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && step_q != '0) |-> cur_q.size_reply)
    else $error("reply step set on a single-result job");

endmodule

// ===== rtl/serial_flash_page_loader_core.sv =====
// Top level of the serial flash page loader.
// Depends on slp_pkg, slp_in_if, slp_out_if, slp_front, slp_fifo and slp_back.
//
// Usage:
//   in_i carries one event per transfer: a host byte, a handshake window tick,
//   a flash readback byte or a flash operation acknowledgement. out_o carries
//   the resulting actions (host bytes, erase, fill, write, read, start); the
//   final result caused by an event has last set.
//   An event's job passes through the job queue into the output register, from
//   which its first result is presented on out_o.
//   Throughput: one event per cycle while the two-entry job queue has room; the
//   output side sends one result per cycle while the receiver is ready, so a '<'
//   in the handshake yields five results, and the queue fills if events outpace results.
//   Each fill step uses a byte pair, and each verify step a byte, prefetched from the
//   page buffer the cycle after the preceding event, so no step waits on a buffer read.
//   Reset (rst_ni low, asynchronous) returns to the handshake phase with no window
//   open and empties the queue and output register; the page buffer is not cleared.
//   When the receiver holds ready low, the current result holds on out_o, the
//   queue fills, and in_i.ready drops once it is full.
module serial_flash_page_loader_core #(
  parameter int PAGE     = 128,
  parameter int ATTEMPTS = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slp_in_if.sink     in_i,
  slp_out_if.source  out_o
);

  slp_pkg::job_t push_job, head_job;
  logic          push, pop, head_valid, full;

  slp_front #(
    .PAGE     (PAGE),
    .ATTEMPTS (ATTEMPTS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  slp_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .valid_o (head_valid),
    .full_o  (full)
  );

  slp_back #(
    .PAGE (PAGE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
